@@ rtl/wpmc_pkg.sv @@
// wpmc_pkg: shared constants, types and state codes for the windowed pair match counter
// no dependencies; used by the interfaces, the compare cells, the window memory and the top level
`default_nettype none

package wpmc_pkg;

	// field widths
	localparam int VAL_W  = 64;
	localparam int RISE_W = 8;
	localparam int DIST_W = 13;
	localparam int CNT_W  = 64;

	// one stored entry: value high, value low, rise count
	localparam int WORD_W = 2 * VAL_W + RISE_W;

	// compare chain: the entry word is split into equal slices, one per cell
	localparam int CELL_N  = 4;
	localparam int SLICE_W = WORD_W / CELL_N;

	// default window store depth and register reset value
	localparam int WINDOW_DEPTH_DEF = 4096;
	localparam logic [DIST_W-1:0] WINDOW_SIZE_RST = DIST_W'(4096);

	// item fill count, saturates well above the largest searchable distance plus two
	localparam int FILL_W = 14;

	// walk sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// what one compare cell hands to the next
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [DIST_W-1:0] gap;
		logic [WORD_W-1:0] data;
	} cell_bus_t;

endpackage

`default_nettype wire

@@ rtl/wpmc_item_if.sv @@
// wpmc_item_if: valid/ready channel carrying one input item
// depends on wpmc_pkg for field widths
`default_nettype none

interface wpmc_item_if;
	logic                       valid;
	logic                       ready;
	logic [wpmc_pkg::VAL_W-1:0]  value_high;
	logic [wpmc_pkg::VAL_W-1:0]  value_low;
	logic [wpmc_pkg::RISE_W-1:0] rise_count;

	modport source (output valid, output value_high, output value_low, output rise_count,
		input ready);
	modport sink (input valid, input value_high, input value_low, input rise_count,
		output ready);
endinterface

`default_nettype wire

@@ rtl/wpmc_result_if.sv @@
// wpmc_result_if: valid/ready channel carrying one result item
// depends on wpmc_pkg for field widths
`default_nettype none

interface wpmc_result_if;
	logic                       valid;
	logic                       ready;
	logic                       matched;
	logic [wpmc_pkg::DIST_W-1:0] distance;
	logic [wpmc_pkg::CNT_W-1:0]  unmatched_total;
	logic [wpmc_pkg::DIST_W-1:0] max_distance;

	modport source (output valid, output matched, output distance, output unmatched_total,
		output max_distance, input ready);
	modport sink (input valid, input matched, input distance, input unmatched_total,
		input max_distance, output ready);
endinterface

`default_nettype wire

@@ rtl/wpmc_cell.sv @@
// wpmc_cell: one compare cell of the match chain, holds one slice of the search key
// depends on wpmc_pkg for the cell bus type and slice geometry
`default_nettype none

module wpmc_cell #(
	parameter int SLICE_IDX = 0
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        flush,
	input  wire logic                        key_load,
	input  wire logic [wpmc_pkg::WORD_W-1:0] key_word,
	input  wire wpmc_pkg::cell_bus_t         prev,
	output wpmc_pkg::cell_bus_t              next
);

	localparam int LSB = SLICE_IDX * wpmc_pkg::SLICE_W;

	logic                          valid_q;
	logic                          hit_q;
	logic [wpmc_pkg::DIST_W-1:0]   dist_q;
	logic [wpmc_pkg::WORD_W-1:0]   data_q;
	logic [wpmc_pkg::SLICE_W-1:0]  key_q;

	// valid moves one cell per cycle, flush drops everything in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flush) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= prev.valid;
		end
	end

	// compare this cell's slice and pass the candidate on
	always_ff @(posedge clk) begin
		hit_q  <= prev.hit && (prev.data[LSB +: wpmc_pkg::SLICE_W] == key_q);
		dist_q <= prev.gap;
		data_q <= prev.data;
		if (key_load) begin
			key_q <= key_word[LSB +: wpmc_pkg::SLICE_W];
		end
	end

	assign next = '{valid: valid_q, hit: hit_q, gap: dist_q, data: data_q};

endmodule

`default_nettype wire

@@ rtl/wpmc_window_ram.sv @@
// wpmc_window_ram: circular store of recent items, one write port and one registered read port
// depends on wpmc_pkg for the entry width
`default_nettype none

module wpmc_window_ram #(
	parameter int DEPTH  = wpmc_pkg::WINDOW_DEPTH_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic [ADDR_W-1:0]           wr_addr,
	input  wire logic [wpmc_pkg::WORD_W-1:0] wr_data,
	input  wire logic                        rd_en,
	input  wire logic [ADDR_W-1:0]           rd_addr,
	output logic      [wpmc_pkg::WORD_W-1:0] rd_data
);

	logic [wpmc_pkg::WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/windowed_pair_match_counter.sv @@
// windowed_pair_match_counter: walks back over the window store for the nearest equal item
// the search over L distances ends at the first match, or once all L reads have left the
// compare chain with no match; the result register is loaded from the done state
// throughput: one item at a time, next item taken the cycle after its result is loaded
// (a held result adds its stall); reads one entry per cycle while searching
// reset clears counters, fill count and window_size (to 4096); the store itself is not cleared
`default_nettype none

module windowed_pair_match_counter #(
	parameter int WINDOW_DEPTH = wpmc_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write_en,
	input  wire logic [wpmc_pkg::DIST_W-1:0] cfg_write_data,
	wpmc_item_if.sink                        item,
	wpmc_result_if.source                    result
);

	localparam int ADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int DIST_W = wpmc_pkg::DIST_W;
	localparam int FILL_W = wpmc_pkg::FILL_W;
	localparam int CNT_W  = wpmc_pkg::CNT_W;
	localparam int CELL_N = wpmc_pkg::CELL_N;

	wpmc_pkg::state_t state_q, state_d;

	logic [DIST_W-1:0]           window_size_q;
	logic [ADDR_W-1:0]           wr_slot_q;
	logic [ADDR_W-1:0]           rd_ptr_q;
	logic [DIST_W-1:0]           remain_q;
	logic [DIST_W-1:0]           issue_dist_q;
	logic [FILL_W-1:0]           fill_q;
	logic [CNT_W-1:0]            unmatched_q;
	logic [DIST_W-1:0]           largest_q;
	logic [wpmc_pkg::WORD_W-1:0] key_q;
	logic                        found_v_q;
	logic [DIST_W-1:0]           found_q;

	logic                        rd_valid_s1;
	logic [DIST_W-1:0]           dist_s1;
	logic [wpmc_pkg::WORD_W-1:0] rd_data;

	logic                        out_valid_q;
	logic                        out_matched_q;
	logic [DIST_W-1:0]           out_distance_q;
	logic [CNT_W-1:0]            out_unmatched_q;
	logic [DIST_W-1:0]           out_max_q;

	logic                        accept;
	logic                        issue;
	logic                        flush;
	logic                        chain_hit;
	logic                        pending;
	logic                        finish;
	logic [DIST_W-1:0]           lim_c;
	logic [wpmc_pkg::WORD_W-1:0] item_word;
	logic [CNT_W-1:0]            unmatched_next;
	logic [DIST_W-1:0]           largest_next;

	wpmc_pkg::cell_bus_t chain [CELL_N+1];

	assign item_word   = {item.value_high, item.value_low, item.rise_count};
	assign item.ready  = (state_q == wpmc_pkg::ST_IDLE);
	assign accept      = item.valid && item.ready;
	assign chain_hit   = chain[CELL_N].valid && chain[CELL_N].hit;
	assign issue       = (state_q == wpmc_pkg::ST_SEARCH) && (remain_q != '0) && !chain_hit;
	assign flush       = accept || ((state_q == wpmc_pkg::ST_SEARCH) && chain_hit);
	assign finish      = (state_q == wpmc_pkg::ST_DONE) && (!out_valid_q || result.ready);

	// searched range: window_size capped by store depth and by items already stored less two
	always_comb begin
		lim_c = window_size_q;
		if (32'(window_size_q) > WINDOW_DEPTH) begin
			lim_c = DIST_W'(WINDOW_DEPTH);
		end
		if (fill_q < FILL_W'(2)) begin
			lim_c = '0;
		end else if ((fill_q - FILL_W'(2)) < FILL_W'(lim_c)) begin
			lim_c = DIST_W'(fill_q - FILL_W'(2));
		end
	end

	// anything still travelling toward the end of the chain
	always_comb begin
		pending = rd_valid_s1;
		for (int i = 1; i < CELL_N; i++) begin
			pending = pending | chain[i].valid;
		end
		pending = pending | chain[CELL_N].valid;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wpmc_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = wpmc_pkg::ST_SEARCH;
				end
			end
			wpmc_pkg::ST_SEARCH: begin
				if (chain_hit || ((remain_q == '0) && !pending)) begin
					state_d = wpmc_pkg::ST_DONE;
				end
			end
			wpmc_pkg::ST_DONE: begin
				if (finish) begin
					state_d = wpmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wpmc_pkg::ST_IDLE;
			end
		endcase
	end

	// counters after this item
	always_comb begin
		unmatched_next = unmatched_q;
		largest_next   = largest_q;
		if (found_v_q) begin
			if (found_q > largest_q) begin
				largest_next = found_q;
			end
		end else if (unmatched_q != '1) begin
			unmatched_next = unmatched_q + CNT_W'(1);
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= wpmc_pkg::ST_IDLE;
			window_size_q <= wpmc_pkg::WINDOW_SIZE_RST;
			wr_slot_q     <= '0;
			fill_q        <= '0;
			unmatched_q   <= '0;
			largest_q     <= '0;
			found_v_q     <= 1'b0;
			rd_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write_en) begin
				window_size_q <= cfg_write_data;
			end
			if (accept) begin
				found_v_q <= 1'b0;
			end else if ((state_q == wpmc_pkg::ST_SEARCH) && chain_hit) begin
				found_v_q <= 1'b1;
			end
			rd_valid_s1 <= issue && !flush;
			if (finish) begin
				wr_slot_q   <= (wr_slot_q == ADDR_W'(WINDOW_DEPTH - 1)) ? '0
					: wr_slot_q + ADDR_W'(1);
				if (fill_q != '1) begin
					fill_q <= fill_q + FILL_W'(1);
				end
				unmatched_q <= unmatched_next;
				largest_q   <= largest_next;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk pointer, distance tags, key and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q        <= item_word;
			remain_q     <= lim_c;
			issue_dist_q <= DIST_W'(1);
			rd_ptr_q     <= (wr_slot_q == '0) ? ADDR_W'(WINDOW_DEPTH - 1)
				: wr_slot_q - ADDR_W'(1);
		end else if (issue) begin
			remain_q     <= remain_q - DIST_W'(1);
			issue_dist_q <= issue_dist_q + DIST_W'(1);
			rd_ptr_q     <= (rd_ptr_q == '0) ? ADDR_W'(WINDOW_DEPTH - 1)
				: rd_ptr_q - ADDR_W'(1);
		end
		dist_s1 <= issue_dist_q;
		if ((state_q == wpmc_pkg::ST_SEARCH) && chain_hit) begin
			found_q <= chain[CELL_N].gap;
		end
		if (finish) begin
			out_matched_q   <= found_v_q;
			out_distance_q  <= found_v_q ? found_q : '0;
			out_unmatched_q <= unmatched_next;
			out_max_q       <= largest_next;
		end
	end

	// window store: read during the walk, the item is written once its search is over
	wpmc_window_ram #(
		.DEPTH  (WINDOW_DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (finish),
		.wr_addr (wr_slot_q),
		.wr_data (key_q),
		.rd_en   (issue),
		.rd_addr (rd_ptr_q),
		.rd_data (rd_data)
	);

	// head of the compare chain
	assign chain[0] = '{valid: rd_valid_s1, hit: 1'b1, gap: dist_s1, data: rd_data};

	// compare chain, one key slice per cell
	for (genvar g = 0; g < CELL_N; g++) begin : g_cell
		wpmc_cell #(
			.SLICE_IDX (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.flush    (flush),
			.key_load (accept),
			.key_word (item_word),
			.prev     (chain[g]),
			.next     (chain[g+1])
		);
	end

	// result channel
	assign result.valid           = out_valid_q;
	assign result.matched         = out_matched_q;
	assign result.distance        = out_distance_q;
	assign result.unmatched_total = out_unmatched_q;
	assign result.max_distance    = out_max_q;

endmodule

`default_nettype wire

@@ sim/tb_windowed_pair_match_counter.sv @@
// tb_windowed_pair_match_counter: self-checking testbench for the windowed pair match counter
// depends on wpmc_pkg, wpmc_item_if, wpmc_result_if and windowed_pair_match_counter

module tb_windowed_pair_match_counter;

	localparam int VAL_W           = wpmc_pkg::VAL_W;
	localparam int RISE_W          = wpmc_pkg::RISE_W;
	localparam int DIST_W          = wpmc_pkg::DIST_W;
	localparam int CNT_W           = wpmc_pkg::CNT_W;
	localparam int DEPTH           = wpmc_pkg::WINDOW_DEPTH_DEF;
	localparam int QUIET_LIMIT     = 20000;
	localparam int TAIL_CYCLES     = 40;
	localparam int POOL_N          = 8;
	localparam int SEG_ITEMS       = 25;

	typedef struct packed {
		logic [VAL_W-1:0]  high;
		logic [VAL_W-1:0]  low;
		logic [RISE_W-1:0] rise;
	} pair_item_t;

	typedef struct packed {
		logic              hit;
		logic [DIST_W-1:0] gap;
		logic [CNT_W-1:0]  unmatched;
		logic [DIST_W-1:0] widest;
	} match_result_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write_en;
	logic [DIST_W-1:0] cfg_write_data;

	wpmc_item_if   item_ch();
	wpmc_result_if result_ch();

	windowed_pair_match_counter i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item           (item_ch),
		.result         (result_ch)
	);

	// shadow of the window store and counters
	logic [VAL_W-1:0]  seen_high [DEPTH];
	logic [VAL_W-1:0]  seen_low [DEPTH];
	logic [RISE_W-1:0] seen_rise [DEPTH];
	int unsigned       next_slot     = 0;
	logic [63:0]       item_pos      = '0;
	logic [CNT_W-1:0]  unmatched_cnt = '0;
	int unsigned       widest_dist   = 0;
	int unsigned       window_size   = wpmc_pkg::WINDOW_SIZE_RST;

	pair_item_t    stim_q[$];
	match_result_t expected_q[$];

	int items_queued = 0;
	int results_seen = 0;
	int errors       = 0;
	int quiet_cycles = 0;
	int idle_pct     = 0;
	int send_gap     = 0;
	int hold_left    = 0;

	// nearest equal item inside the window, then counter and store update
	function automatic match_result_t predict_match(pair_item_t it);
		int unsigned   span;
		int unsigned   d;
		int unsigned   slot;
		int unsigned   found;
		match_result_t r;
		span = (window_size > DEPTH) ? DEPTH : window_size;
		if (item_pos < 2)
			span = 0;
		else if (item_pos - 2 < span)
			span = 32'(item_pos - 2);
		found = 0;
		for (d = 1; d <= span && found == 0; d++) begin
			slot = (next_slot + DEPTH - d) % DEPTH;
			if (seen_high[slot] == it.high && seen_low[slot] == it.low &&
					seen_rise[slot] == it.rise)
				found = d;
		end
		if (found != 0) begin
			if (found > widest_dist)
				widest_dist = found;
		end else if (unmatched_cnt != '1) begin
			unmatched_cnt++;
		end
		seen_high[next_slot] = it.high;
		seen_low[next_slot]  = it.low;
		seen_rise[next_slot] = it.rise;
		next_slot = (next_slot + 1) % DEPTH;
		item_pos++;
		r.hit       = (found != 0);
		r.gap       = DIST_W'(found);
		r.unmatched = unmatched_cnt;
		r.widest    = DIST_W'(widest_dist);
		return r;
	endfunction

	function automatic pair_item_t rand_item();
		pair_item_t it;
		it.high = {$urandom, $urandom};
		it.low  = {$urandom, $urandom};
		it.rise = RISE_W'($urandom_range(0, 255));
		return it;
	endfunction

	task automatic queue_item(input pair_item_t it);
		stim_q.push_back(it);
		items_queued++;
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
	endtask

	// window writes only once every result is back
	task automatic set_window(input int unsigned size);
		while (results_seen != items_queued)
			@(posedge clk);
		@(posedge clk);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= DIST_W'(size);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		window_size = size;
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// item driver with random send gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				expected_q.push_back(predict_match({item_ch.value_high, item_ch.value_low,
					item_ch.rise_count}));
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (stim_q.size() != 0) begin
					pair_item_t nxt;
					nxt = stim_q.pop_front();
					item_ch.valid      <= 1'b1;
					item_ch.value_high <= nxt.high;
					item_ch.value_low  <= nxt.low;
					item_ch.rise_count <= nxt.rise;
					if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
						send_gap = $urandom_range(1, 3);
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stalls
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, expected none, actual %0d/%0d",
						$time, result_ch.matched, result_ch.distance);
				end else begin
					match_result_t want;
					want = expected_q.pop_front();
					if (result_ch.matched !== want.hit)
						report_mismatch("matched", want.hit, result_ch.matched);
					if (result_ch.distance !== want.gap)
						report_mismatch("distance", want.gap, result_ch.distance);
					if (result_ch.unmatched_total !== want.unmatched)
						report_mismatch("unmatched_total", want.unmatched,
							result_ch.unmatched_total);
					if (result_ch.max_distance !== want.widest)
						report_mismatch("max_distance", want.widest, result_ch.max_distance);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					hold_left = $urandom_range(1, 3);
			end
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// stimulus sequence
	initial begin
		pair_item_t  a;
		pair_item_t  b;
		pair_item_t  c;
		pair_item_t  it;
		pair_item_t  pool [POOL_N];
		int unsigned seg_window [4];
		int          seg_idle [4];
		int          seg;
		int          k;
		int          pick;

		cfg_write_en       = 1'b0;
		cfg_write_data     = '0;
		item_ch.valid      = 1'b0;
		item_ch.value_high = '0;
		item_ch.value_low  = '0;
		item_ch.rise_count = '0;
		result_ch.ready    = 1'b0;
		arst_n             = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset window size
		idle_pct = 25;
		a = {{VAL_W{1'b1}}, {VAL_W{1'b1}}, {RISE_W{1'b1}}};
		b = '0;
		c = {{(VAL_W/2){2'b01}}, {(VAL_W/2){2'b10}}, {(RISE_W/2){2'b01}}};
		queue_item(a);
		queue_item(b);
		queue_item(c);
		// item 1 lies out of reach of the search from item 3
		queue_item(b);
		// item 0 lies out of reach of the search from item 4
		queue_item(a);
		queue_item(a);
		queue_item(c);
		queue_item(c);
		queue_item(b);
		// near misses: one field off by one bit
		it = a;
		it.rise[0] = 1'b0;
		queue_item(it);
		it = a;
		it.high[VAL_W-1] = 1'b0;
		queue_item(it);
		it = a;
		it.low[0] = 1'b0;
		queue_item(it);
		queue_item(~c);
		queue_item(a);

		// empty window searches nothing
		set_window(0);
		queue_item(a);
		queue_item(a);
		queue_item(a);

		// window of one reaches only the previous item
		set_window(1);
		queue_item(b);
		queue_item(b);
		queue_item(a);
		queue_item(b);

		// random segments over a small value pool, mixed with near misses and noise
		seg_window[0] = $urandom_range(2, 16);
		seg_window[1] = 8191;
		seg_window[2] = $urandom_range(17, 200);
		seg_window[3] = $urandom_range(0, 8191);
		seg_idle[0] = 30;
		seg_idle[1] = 0;
		seg_idle[2] = 20;
		seg_idle[3] = 35;
		for (seg = 0; seg < 4; seg++) begin
			set_window(seg_window[seg]);
			idle_pct = seg_idle[seg];
			foreach (pool[k])
				pool[k] = rand_item();
			for (k = 0; k < SEG_ITEMS; k++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					it = pool[$urandom_range(0, POOL_N - 1)];
				end else if (pick < 75) begin
					it = pool[$urandom_range(0, POOL_N - 1)];
					it = pair_item_t'(it ^ ($bits(pair_item_t)'(1) <<
						$urandom_range(0, $bits(pair_item_t) - 1)));
				end else begin
					it = rand_item();
				end
				queue_item(it);
			end
		end

		// last stretch without idling
		set_window(6);
		idle_pct = 0;
		for (k = 0; k < 20; k++) begin
			if ($urandom_range(0, 99) < 60)
				queue_item(pool[$urandom_range(0, POOL_N - 1)]);
			else
				queue_item(rand_item());
		end

		while (results_seen != items_queued)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			errors++;
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				expected_q.size());
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ files.f @@
rtl/wpmc_pkg.sv
rtl/wpmc_item_if.sv
rtl/wpmc_result_if.sv
rtl/wpmc_cell.sv
rtl/wpmc_window_ram.sv
rtl/windowed_pair_match_counter.sv
sim/tb_windowed_pair_match_counter.sv
